@@ rtl/atg_pkg.sv @@
// ----------------------------------------------------------------------------
// atg_pkg
// Shared constants, types and helper functions of the text grid terminal.
// ----------------------------------------------------------------------------
package atg_pkg;

    localparam int GRID_ROWS = 32;
    localparam int GRID_COLS = 64;
    localparam int TAB_WIDTH = 8;

    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int CCOL_W     = $clog2(GRID_COLS + 1);
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int ADDR_XW    = ADDR_W + 1;
    localparam int TAB_MAXK   = GRID_COLS / TAB_WIDTH + 1;

    localparam int CH_W      = 7;
    localparam int RD_ROW_W  = 5;
    localparam int RD_COL_W  = 6;
    localparam int NUM_W     = 16;

    localparam logic [CH_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CH_W-1:0] CH_QMARK = 7'h3f;

    // operation codes from the front parser to the back executor
    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_READ    = 4'd1;
    localparam logic [3:0] OP_CR      = 4'd2;
    localparam logic [3:0] OP_LF      = 4'd3;
    localparam logic [3:0] OP_BS      = 4'd4;
    localparam logic [3:0] OP_TAB     = 4'd5;
    localparam logic [3:0] OP_PUT     = 4'd6;
    localparam logic [3:0] OP_SAVE    = 4'd7;
    localparam logic [3:0] OP_RESTORE = 4'd8;
    localparam logic [3:0] OP_RI      = 4'd9;
    localparam logic [3:0] OP_RESET   = 4'd10;
    localparam logic [3:0] OP_CSI     = 4'd11;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [3:0]          code;
        logic [CH_W-1:0]     ch;
        logic [RD_ROW_W-1:0] rd_row;
        logic [RD_COL_W-1:0] rd_col;
        logic [7:0]          fin;
        logic [NUM_W-1:0]    n1;
        logic [NUM_W-1:0]    n2;
        logic                has2;
        logic                priv;
        logic                esc;
    } t_op;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

    function automatic logic [NUM_W-1:0] add_digit(logic [NUM_W-1:0] v, logic [3:0] d);
        logic [NUM_W+3:0] t;
        t = (NUM_W+4)'(v) * (NUM_W+4)'(10) + (NUM_W+4)'(d);
        return (t > (NUM_W+4)'(65535)) ? NUM_W'(65535) : t[NUM_W-1:0];
    endfunction

    // next tab stop, clamped to the last column
    function automatic logic [CCOL_W-1:0] tab_stop(logic [CCOL_W-1:0] col);
        logic [CCOL_W-1:0] res;
        res = CCOL_W'(GRID_COLS - 1);
        for (int k = TAB_MAXK; k >= 1; k--) begin
            if (k * TAB_WIDTH > int'(col)) begin
                res = (k * TAB_WIDTH > GRID_COLS - 1) ? CCOL_W'(GRID_COLS - 1)
                                                      : CCOL_W'(k * TAB_WIDTH);
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/atg_if.sv @@
// ----------------------------------------------------------------------------
// atg channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface atg_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [7:0]                    data_byte;
    logic [atg_pkg::RD_ROW_W-1:0]  read_row;
    logic [atg_pkg::RD_COL_W-1:0]  read_col;

    modport source(output valid, command, data_byte, read_row, read_col, input ready);
    modport sink(input valid, command, data_byte, read_row, read_col, output ready);
endinterface

interface atg_out_if;
    logic                        valid;
    logic                        ready;
    logic [atg_pkg::CH_W-1:0]    cell_char;
    logic [atg_pkg::ROW_W-1:0]   cursor_row;
    logic [atg_pkg::CCOL_W-1:0]  cursor_col;
    logic                        cursor_shown;
    logic                        in_escape;

    modport source(output valid, cell_char, cursor_row, cursor_col, cursor_shown, in_escape,
                   input ready);
    modport sink(input valid, cell_char, cursor_row, cursor_col, cursor_shown, in_escape,
                 output ready);
endinterface

@@ rtl/atg_front.sv @@
// ----------------------------------------------------------------------------
// atg_front
// Accepts input items, runs the escape parser and emits one operation per item.
// ----------------------------------------------------------------------------
module atg_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    atg_in_if.sink                i_in,
    input  atg_pkg::t_back_status i_status,
    input  logic                  i_full,
    output logic                  o_push,
    output atg_pkg::t_op          o_op
);

    localparam logic [2:0] PS_GROUND  = 3'd0;
    localparam logic [2:0] PS_ESC     = 3'd1;
    localparam logic [2:0] PS_CSI     = 3'd2;
    localparam logic [2:0] PS_OSC     = 3'd3;
    localparam logic [2:0] PS_OSC_ESC = 3'd4;
    localparam logic [2:0] PS_CHARSET = 3'd5;

    logic [2:0]                  r_pst, n_pst;
    logic [atg_pkg::NUM_W-1:0]   r_n1, n_n1, r_n2, n_n2;
    logic [2:0]                  r_idx, n_idx;
    logic                        r_priv, n_priv;
    logic [7:0]                  b;
    logic [3:0]                  dig;

    assign i_in.ready = !i_full && !i_status.init_busy;
    assign o_push     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;
    assign dig        = b[3:0];

    always_comb begin
        n_pst  = r_pst;
        n_n1   = r_n1;
        n_n2   = r_n2;
        n_idx  = r_idx;
        n_priv = r_priv;
        o_op        = '0;
        o_op.code   = atg_pkg::OP_NOP;
        o_op.rd_row = i_in.read_row;
        o_op.rd_col = i_in.read_col;
        if (i_in.command) begin
            o_op.code = atg_pkg::OP_READ;
        end else begin
            case (r_pst)
                PS_GROUND: begin
                    if (b == 8'h1b) begin
                        n_pst = PS_ESC;
                    end else if (b == 8'h0d) begin
                        o_op.code = atg_pkg::OP_CR;
                    end else if (b == 8'h0a || b == 8'h0b || b == 8'h0c) begin
                        o_op.code = atg_pkg::OP_LF;
                    end else if (b == 8'h08) begin
                        o_op.code = atg_pkg::OP_BS;
                    end else if (b == 8'h09) begin
                        o_op.code = atg_pkg::OP_TAB;
                    end else if (b >= 8'h20 && b < 8'h7f) begin
                        o_op.code = atg_pkg::OP_PUT;
                        o_op.ch   = b[6:0];
                    end else if (b >= 8'hc0) begin
                        // utf-8 lead byte shows as a question mark
                        o_op.code = atg_pkg::OP_PUT;
                        o_op.ch   = atg_pkg::CH_QMARK;
                    end
                end
                PS_ESC: begin
                    n_pst = PS_GROUND;
                    if (b == 8'h5b) begin
                        n_pst  = PS_CSI;
                        n_n1   = '0;
                        n_n2   = '0;
                        n_idx  = '0;
                        n_priv = 1'b0;
                    end else if (b == 8'h5d) begin
                        n_pst = PS_OSC;
                    end else if (b == 8'h28 || b == 8'h29) begin
                        n_pst = PS_CHARSET;
                    end else if (b == 8'h37) begin
                        o_op.code = atg_pkg::OP_SAVE;
                    end else if (b == 8'h38) begin
                        o_op.code = atg_pkg::OP_RESTORE;
                    end else if (b == 8'h4d) begin
                        o_op.code = atg_pkg::OP_RI;
                    end else if (b == 8'h63) begin
                        o_op.code = atg_pkg::OP_RESET;
                    end
                end
                PS_CSI: begin
                    if (b == 8'h3f) begin
                        n_priv = 1'b1;
                    end else if (b >= 8'h30 && b <= 8'h39) begin
                        if (r_idx == 3'd0) begin
                            n_n1 = atg_pkg::add_digit(r_n1, dig);
                        end else if (r_idx == 3'd1) begin
                            n_n2 = atg_pkg::add_digit(r_n2, dig);
                        end
                    end else if (b == 8'h3b) begin
                        if (r_idx != 3'd7) begin
                            n_idx = r_idx + 3'd1;
                        end
                    end else if (b >= 8'h40 && b <= 8'h7e) begin
                        o_op.code = atg_pkg::OP_CSI;
                        o_op.fin  = b;
                        o_op.n1   = r_n1;
                        o_op.n2   = r_n2;
                        o_op.has2 = (r_idx != 3'd0);
                        o_op.priv = r_priv;
                        n_pst     = PS_GROUND;
                    end
                end
                PS_OSC: begin
                    if (b == 8'h07) begin
                        n_pst = PS_GROUND;
                    end else if (b == 8'h1b) begin
                        n_pst = PS_OSC_ESC;
                    end
                end
                default: begin
                    n_pst = PS_GROUND;
                end
            endcase
        end
        o_op.esc = (n_pst != PS_GROUND);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pst  <= PS_GROUND;
            r_n1   <= '0;
            r_n2   <= '0;
            r_idx  <= '0;
            r_priv <= 1'b0;
        end else if (o_push) begin
            r_pst  <= n_pst;
            r_n1   <= n_n1;
            r_n2   <= n_n2;
            r_idx  <= n_idx;
            r_priv <= n_priv;
        end
    end

`ifndef SYNTHESIS
    a_no_push_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.init_busy |-> !o_push)
        else $error("item accepted during clearing pass");
`endif

endmodule

@@ rtl/atg_queue.sv @@
// ----------------------------------------------------------------------------
// atg_queue
// Short operation queue between the parser front and the grid back.
// ----------------------------------------------------------------------------
module atg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  atg_pkg::t_op  i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output atg_pkg::t_op  o_op
);

    atg_pkg::t_op                r_mem [atg_pkg::QDEPTH];
    logic [atg_pkg::QPTR_W-1:0]  r_wp, r_rp;
    logic [atg_pkg::QPTR_W:0]    r_cnt;

    assign o_full  = (r_cnt == (atg_pkg::QPTR_W+1)'(atg_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (atg_pkg::QPTR_W+1)'(i_push) - (atg_pkg::QPTR_W+1)'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue underflow");
`endif

endmodule

@@ rtl/atg_back.sv @@
// ----------------------------------------------------------------------------
// atg_back
// Executes parser operations on the cursor and the character grid memory.
// ----------------------------------------------------------------------------
module atg_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  atg_pkg::t_op           i_op,
    output logic                   o_pop,
    output atg_pkg::t_back_status  o_status,
    atg_out_if.source              o_out
);

    localparam logic [2:0] BS_IDLE   = 3'd0;
    localparam logic [2:0] BS_READ   = 3'd1;
    localparam logic [2:0] BS_SCR_RD = 3'd2;
    localparam logic [2:0] BS_SCR_WR = 3'd3;
    localparam logic [2:0] BS_FILL   = 3'd4;
    localparam logic [2:0] BS_PUT    = 3'd5;

    localparam int AW  = atg_pkg::ADDR_W;
    localparam int XW  = atg_pkg::ADDR_XW;
    localparam int RW  = atg_pkg::ROW_W;
    localparam int CW  = atg_pkg::CCOL_W;
    localparam int SW  = atg_pkg::NUM_W + 2;

    localparam logic [AW-1:0] LAST_BASE = AW'((atg_pkg::GRID_ROWS - 1) * atg_pkg::GRID_COLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(atg_pkg::GRID_CELLS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(atg_pkg::GRID_ROWS - 1);
    localparam logic [CW-1:0] COL_LAST  = CW'(atg_pkg::GRID_COLS - 1);
    localparam logic [CW-1:0] COL_END   = CW'(atg_pkg::GRID_COLS);

    logic [atg_pkg::CH_W-1:0] r_grid [atg_pkg::GRID_CELLS];
    logic [atg_pkg::CH_W-1:0] r_rdata;

    logic [2:0]               r_state, n_state;
    logic [AW-1:0]            r_addr, n_addr, r_end, n_end;
    logic                     r_emit, n_emit, r_pend, n_pend, r_esc, n_esc;
    logic                     r_rdok, n_rdok, r_init, n_init;
    logic [atg_pkg::CH_W-1:0] r_pch, n_pch;
    logic [RW-1:0]            r_row, n_row, r_srow, n_srow;
    logic [CW-1:0]            r_col, n_col, r_scol, n_scol;
    logic                     r_con, n_con;

    logic                     r_ov;
    logic [atg_pkg::CH_W-1:0] r_ocell;
    logic [RW-1:0]            r_orow;
    logic [CW-1:0]            r_ocol;
    logic                     r_ocon, r_oesc;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic [atg_pkg::CH_W-1:0] mem_wdata;
    logic                     emit;
    logic [atg_pkg::CH_W-1:0] emit_cell;

    logic [XW-1:0]            base, cur_addr, row_end, fs, fe;
    logic [CW-1:0]            ecol;
    logic                     fill_go;
    logic [SW-1:0]            f1, f2, rsum, csum;
    logic [SW-1:0]            row_x, col_x;
    logic                     rd_ok;

    assign o_status.init_busy = r_init;
    assign o_out.valid        = r_ov;
    assign o_out.cell_char    = r_ocell;
    assign o_out.cursor_row   = r_orow;
    assign o_out.cursor_col   = r_ocol;
    assign o_out.cursor_shown = r_ocon;
    assign o_out.in_escape    = r_oesc;

    always_comb begin
        base     = XW'(r_row) * XW'(atg_pkg::GRID_COLS);
        cur_addr = base + XW'(r_col);
        ecol     = (r_col > COL_LAST) ? COL_LAST : r_col;
        row_end  = base + XW'(atg_pkg::GRID_COLS - 1);
        row_x    = SW'(r_row);
        col_x    = SW'(r_col);
        f1       = (i_op.n1 == '0) ? SW'(1) : SW'(i_op.n1);
        f2       = (!i_op.has2 || i_op.n2 == '0) ? SW'(1) : SW'(i_op.n2);
        rsum     = row_x + f1;
        csum     = col_x + f1;
        rd_ok    = (int'(i_op.rd_row) < atg_pkg::GRID_ROWS) &&
                   (int'(i_op.rd_col) < atg_pkg::GRID_COLS);
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_end   = r_end;
        n_emit  = r_emit;
        n_pend  = r_pend;
        n_pch   = r_pch;
        n_esc   = r_esc;
        n_rdok  = r_rdok;
        n_init  = r_init;
        n_row   = r_row;
        n_col   = r_col;
        n_srow  = r_srow;
        n_scol  = r_scol;
        n_con   = r_con;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = atg_pkg::CH_SPACE;
        mem_raddr = r_addr;
        o_pop     = 1'b0;
        emit      = 1'b0;
        emit_cell = '0;
        fill_go   = 1'b0;
        fs        = '0;
        fe        = '0;
        case (r_state)
            BS_IDLE: begin
                if (!i_empty && !r_ov) begin
                    o_pop = 1'b1;
                    n_esc = i_op.esc;
                    emit  = 1'b1;
                    case (i_op.code)
                        atg_pkg::OP_READ: begin
                            mem_raddr = AW'(XW'(i_op.rd_row) * XW'(atg_pkg::GRID_COLS)
                                            + XW'(i_op.rd_col));
                            n_rdok  = rd_ok;
                            n_state = BS_READ;
                            emit    = 1'b0;
                        end
                        atg_pkg::OP_CR: n_col = '0;
                        atg_pkg::OP_LF: begin
                            if (r_row != ROW_LAST) begin
                                n_row = r_row + 1'b1;
                            end else begin
                                n_addr  = AW'(atg_pkg::GRID_COLS);
                                n_state = BS_SCR_RD;
                                n_emit  = 1'b1;
                                emit    = 1'b0;
                            end
                        end
                        atg_pkg::OP_BS: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                            end
                        end
                        atg_pkg::OP_TAB: n_col = atg_pkg::tab_stop(r_col);
                        atg_pkg::OP_PUT: begin
                            if (r_col >= COL_END) begin
                                // deferred wrap: new line first
                                n_col = CW'(1);
                                if (r_row != ROW_LAST) begin
                                    n_row     = r_row + 1'b1;
                                    mem_we    = 1'b1;
                                    mem_waddr = AW'(base + XW'(atg_pkg::GRID_COLS));
                                    mem_wdata = i_op.ch;
                                end else begin
                                    n_col   = '0;
                                    n_pend  = 1'b1;
                                    n_pch   = i_op.ch;
                                    n_addr  = AW'(atg_pkg::GRID_COLS);
                                    n_state = BS_SCR_RD;
                                    n_emit  = 1'b1;
                                    emit    = 1'b0;
                                end
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(cur_addr);
                                mem_wdata = i_op.ch;
                                n_col     = r_col + 1'b1;
                            end
                        end
                        atg_pkg::OP_SAVE: begin
                            n_srow = r_row;
                            n_scol = r_col;
                        end
                        atg_pkg::OP_RESTORE: begin
                            n_row = r_srow;
                            n_col = r_scol;
                        end
                        atg_pkg::OP_RI: begin
                            if (r_row != '0) begin
                                n_row = r_row - 1'b1;
                            end
                        end
                        atg_pkg::OP_RESET: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_srow  = '0;
                            n_scol  = '0;
                            n_con   = 1'b1;
                            fill_go = 1'b1;
                            fs      = '0;
                            fe      = XW'(LAST_CELL);
                        end
                        atg_pkg::OP_CSI: begin
                            case (i_op.fin)
                                8'h41: n_row = (f1 > row_x) ? '0 : RW'(row_x - f1);
                                8'h42: n_row = (rsum > SW'(ROW_LAST)) ? ROW_LAST : RW'(rsum);
                                8'h43: n_col = (csum > SW'(COL_LAST)) ? COL_LAST : CW'(csum);
                                8'h44: n_col = (f1 >= col_x) ? '0 : CW'(col_x - f1);
                                8'h47: n_col = (f1 - 1'b1 > SW'(COL_LAST)) ? COL_LAST
                                                                           : CW'(f1 - 1'b1);
                                8'h64: n_row = (f1 - 1'b1 > SW'(ROW_LAST)) ? ROW_LAST
                                                                           : RW'(f1 - 1'b1);
                                8'h48, 8'h66: begin
                                    n_row = (f1 - 1'b1 > SW'(ROW_LAST)) ? ROW_LAST
                                                                        : RW'(f1 - 1'b1);
                                    n_col = (f2 - 1'b1 > SW'(COL_LAST)) ? COL_LAST
                                                                        : CW'(f2 - 1'b1);
                                end
                                8'h4a: begin
                                    if (i_op.n1 == 16'd0) begin
                                        fill_go = 1'b1;
                                        fs      = cur_addr;
                                        fe      = XW'(LAST_CELL);
                                    end else if (i_op.n1 == 16'd1) begin
                                        fill_go = 1'b1;
                                        fs      = '0;
                                        fe      = base + XW'(ecol);
                                    end else if (i_op.n1 == 16'd2) begin
                                        fill_go = 1'b1;
                                        fs      = '0;
                                        fe      = XW'(LAST_CELL);
                                    end
                                end
                                8'h4b: begin
                                    if (i_op.n1 == 16'd0) begin
                                        fill_go = 1'b1;
                                        fs      = cur_addr;
                                        fe      = row_end;
                                    end else if (i_op.n1 == 16'd1) begin
                                        fill_go = 1'b1;
                                        fs      = base;
                                        fe      = base + XW'(ecol);
                                    end else if (i_op.n1 == 16'd2) begin
                                        fill_go = 1'b1;
                                        fs      = base;
                                        fe      = row_end;
                                    end
                                end
                                8'h68: begin
                                    if (i_op.priv && i_op.n1 == 16'd25) begin
                                        n_con = 1'b1;
                                    end
                                end
                                8'h6c: begin
                                    if (i_op.priv && i_op.n1 == 16'd25) begin
                                        n_con = 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                    // an empty erase range finishes at once
                    if (fill_go && fs <= fe) begin
                        n_addr  = AW'(fs);
                        n_end   = AW'(fe);
                        n_emit  = 1'b1;
                        n_state = BS_FILL;
                        emit    = 1'b0;
                    end
                end
            end
            BS_READ: begin
                emit      = 1'b1;
                emit_cell = r_rdok ? r_rdata : '0;
                n_state   = BS_IDLE;
            end
            BS_SCR_RD: begin
                n_state = BS_SCR_WR;
            end
            BS_SCR_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr - AW'(atg_pkg::GRID_COLS);
                mem_wdata = r_rdata;
                if (r_addr == LAST_CELL) begin
                    n_addr  = LAST_BASE;
                    n_end   = LAST_CELL;
                    n_state = BS_FILL;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_state = BS_SCR_RD;
                end
            end
            BS_FILL: begin
                mem_we = 1'b1;
                if (r_addr == r_end) begin
                    n_init = 1'b0;
                    if (r_pend) begin
                        n_state = BS_PUT;
                    end else begin
                        n_state = BS_IDLE;
                        emit    = r_emit;
                    end
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            BS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = LAST_BASE;
                mem_wdata = r_pch;
                n_col     = CW'(1);
                n_pend    = 1'b0;
                emit      = 1'b1;
                n_state   = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_grid[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ocell <= emit_cell;
            r_orow  <= n_row;
            r_ocol  <= n_col;
            r_ocon  <= n_con;
            r_oesc  <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // clearing pass over the whole grid after reset
            r_state <= BS_FILL;
            r_addr  <= '0;
            r_end   <= LAST_CELL;
            r_emit  <= 1'b0;
            r_pend  <= 1'b0;
            r_pch   <= '0;
            r_esc   <= 1'b0;
            r_rdok  <= 1'b0;
            r_init  <= 1'b1;
            r_row   <= '0;
            r_col   <= '0;
            r_srow  <= '0;
            r_scol  <= '0;
            r_con   <= 1'b1;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_end   <= n_end;
            r_emit  <= n_emit;
            r_pend  <= n_pend;
            r_pch   <= n_pch;
            r_esc   <= n_esc;
            r_rdok  <= n_rdok;
            r_init  <= n_init;
            r_row   <= n_row;
            r_col   <= n_col;
            r_srow  <= n_srow;
            r_scol  <= n_scol;
            r_con   <= n_con;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !r_ov)
        else $error("result shown during clearing pass");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_END && r_scol <= COL_END)
        else $error("cursor column out of range");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_LAST && r_srow <= ROW_LAST)
        else $error("cursor row out of range");
    a_scroll_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BS_SCR_RD |=> r_state == BS_SCR_WR)
        else $error("scroll read not followed by write");
    a_pend_only_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_row == ROW_LAST)
        else $error("pending wrapped char away from bottom row");
`endif

endmodule

@@ rtl/ansi_terminal_text_grid_top.sv @@
// ----------------------------------------------------------------------------
// ansi_terminal_text_grid_top
// Terminal byte parser with cursor and character grid; one result per item.
// ----------------------------------------------------------------------------
//  port     dir  payload                                            handshake
//  i_in     in   command, data_byte, read_row, read_col             valid/ready
//  o_out    out  cell_char, cursor_row, cursor_col, cursor_shown,   valid/ready
//                in_escape
//
//  most items reach the output through the queue and the output register; a read
//  also passes the grid read register; a scroll reads and rewrites each moved cell
//  and then blanks one row; an erase blanks its cells one by one, as a full reset does
//  after reset a clearing pass over all 2048 cells runs before the first transfer
//  a 4-entry queue lets the parser accept items while the grid is busy
// ----------------------------------------------------------------------------
module ansi_terminal_text_grid_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    atg_in_if.sink     i_in,
    atg_out_if.source  o_out
);

    atg_pkg::t_op          push_op, pop_op;
    atg_pkg::t_back_status status;
    logic                  push, pop, full, empty;

    atg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_status (status),
        .i_full   (full),
        .o_push   (push),
        .o_op     (push_op)
    );

    atg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_op    (pop_op)
    );

    atg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_op     (pop_op),
        .o_pop    (pop),
        .o_status (status),
        .o_out    (o_out)
    );

endmodule
